// ----- rtl/core/csep_pkg.sv -----
// package for the compact song event parser
// shared types, codes and constants; no dependencies

package csep_pkg;

    localparam int ACC_W = 28;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam logic [1:0] KIND_CHAN  = 2'd0;
    localparam logic [1:0] KIND_SYSEX = 2'd1;
    localparam logic [1:0] KIND_EOT   = 2'd2;

    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_END_TRACK   = 8'hF2;
    localparam logic [7:0] ST_DELAY8      = 8'hF3;
    localparam logic [7:0] ST_DELAY16     = 8'hF4;
    localparam logic [7:0] ST_META        = 8'hFF;
    localparam logic [7:0] META_EOT       = 8'h2F;

    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_AFTER    = 4'hA;
    localparam logic [3:0] HI_CTRL     = 4'hB;
    localparam logic [3:0] HI_PROG     = 4'hC;
    localparam logic [3:0] HI_CHPRESS  = 4'hD;
    localparam logic [3:0] HI_BEND     = 4'hE;
    localparam logic [3:0] HI_SYSTEM   = 4'hF;

    localparam logic [6:0] NOTE_OFF_VEL_RESET = 7'd64;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_ONE,
        PH_TWO_A,
        PH_TWO_B,
        PH_DLY8,
        PH_DLY16_LO,
        PH_DLY16_HI,
        PH_SYSEX
    } phase_t;

    // one result as it leaves the block
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       status;
        logic [7:0]       data_first;
        logic [7:0]       data_second;
        logic [ACC_W-1:0] delta_ticks;
        logic             error;
    } result_t;

    // one queued request: a first result and an optional trailing end of track
    typedef struct packed {
        result_t first;
        logic    second_eot;
    } request_t;

endpackage

// ----- rtl/core/csep_front.sv -----
// front end: accepts stream bytes, tracks parse state and delay, builds requests
// depends on csep_pkg

module csep_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               in_byte,
    input  logic                     stream_end,
    input  logic                     cfg_write,
    input  logic [6:0]               cfg_data,
    output logic                     push,
    output csep_pkg::request_t       push_data
);

    csep_pkg::phase_t               phase_reg, phase_next;
    logic [7:0]                     held_status_reg, held_status_next;
    logic [7:0]                     held_first_reg, held_first_next;
    logic [csep_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic                           ended_reg, ended_next;
    logic [6:0]                     nov_reg;

    logic [csep_pkg::ACC_W:0]       sum;
    logic [15:0]                    add_val;
    logic                           do_add;
    logic [csep_pkg::ACC_W-1:0]     acc_mid;
    logic                           emit1;
    logic                           eot1;
    logic                           err1;
    csep_pkg::result_t              res1;

    assign sum     = {1'b0, acc_reg} + {{(csep_pkg::ACC_W - 15){1'b0}}, add_val};
    assign acc_mid = !do_add ? acc_reg
                   : (sum[csep_pkg::ACC_W] ? csep_pkg::ACC_MAX : sum[csep_pkg::ACC_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= csep_pkg::PH_CMD;
            held_status_reg <= '0;
            held_first_reg  <= '0;
            acc_reg         <= '0;
            ended_reg       <= 1'b0;
            nov_reg         <= csep_pkg::NOTE_OFF_VEL_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            held_status_reg <= held_status_next;
            held_first_reg  <= held_first_next;
            acc_reg         <= acc_next;
            ended_reg       <= ended_next;
            if (cfg_write)
            begin
                nov_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        held_status_next = held_status_reg;
        held_first_next  = held_first_reg;
        ended_next       = ended_reg;
        acc_next         = acc_reg;
        add_val          = '0;
        do_add           = 1'b0;
        emit1            = 1'b0;
        eot1             = 1'b0;
        err1             = 1'b0;
        res1             = '0;
        push             = 1'b0;
        push_data        = '0;

        if (accept && !ended_reg)
        begin
            case (phase_reg)
                csep_pkg::PH_CMD:
                begin
                    case (in_byte[7:4])
                        csep_pkg::HI_NOTE_OFF, csep_pkg::HI_PROG, csep_pkg::HI_CHPRESS:
                        begin
                            held_status_next = in_byte;
                            phase_next       = csep_pkg::PH_ONE;
                        end
                        csep_pkg::HI_NOTE_ON, csep_pkg::HI_AFTER, csep_pkg::HI_CTRL,
                        csep_pkg::HI_BEND:
                        begin
                            held_status_next = in_byte;
                            phase_next       = csep_pkg::PH_TWO_A;
                        end
                        csep_pkg::HI_SYSTEM:
                        begin
                            case (in_byte)
                                csep_pkg::ST_SYSEX_START: phase_next = csep_pkg::PH_SYSEX;
                                csep_pkg::ST_END_TRACK:   eot1 = 1'b1;
                                csep_pkg::ST_DELAY8:      phase_next = csep_pkg::PH_DLY8;
                                csep_pkg::ST_DELAY16:     phase_next = csep_pkg::PH_DLY16_LO;
                                default:
                                begin
                                    eot1 = 1'b1;
                                    err1 = 1'b1;
                                end
                            endcase
                        end
                        default:
                        begin
                            eot1 = 1'b1;
                            err1 = 1'b1;
                        end
                    endcase
                end
                csep_pkg::PH_ONE:
                begin
                    phase_next       = csep_pkg::PH_CMD;
                    emit1            = 1'b1;
                    res1.kind        = csep_pkg::KIND_CHAN;
                    res1.status      = held_status_reg;
                    res1.data_first  = in_byte;
                    res1.data_second = (held_status_reg[7:4] == csep_pkg::HI_NOTE_OFF)
                                       ? {1'b0, nov_reg} : 8'd0;
                end
                csep_pkg::PH_TWO_A:
                begin
                    held_first_next = in_byte;
                    phase_next      = csep_pkg::PH_TWO_B;
                end
                csep_pkg::PH_TWO_B:
                begin
                    phase_next       = csep_pkg::PH_CMD;
                    emit1            = 1'b1;
                    res1.kind        = csep_pkg::KIND_CHAN;
                    res1.status      = held_status_reg;
                    res1.data_first  = held_first_reg;
                    res1.data_second = in_byte;
                end
                csep_pkg::PH_DLY8:
                begin
                    do_add     = 1'b1;
                    add_val    = {8'd0, in_byte};
                    phase_next = csep_pkg::PH_CMD;
                end
                csep_pkg::PH_DLY16_LO:
                begin
                    held_first_next = in_byte;
                    phase_next      = csep_pkg::PH_DLY16_HI;
                end
                csep_pkg::PH_DLY16_HI:
                begin
                    do_add     = 1'b1;
                    add_val    = {in_byte, held_first_reg};
                    phase_next = csep_pkg::PH_CMD;
                end
                csep_pkg::PH_SYSEX:
                begin
                    emit1           = 1'b1;
                    res1.kind       = csep_pkg::KIND_SYSEX;
                    res1.status     = csep_pkg::ST_SYSEX_START;
                    res1.data_first = in_byte;
                    if (in_byte == csep_pkg::ST_SYSEX_END)
                    begin
                        phase_next = csep_pkg::PH_CMD;
                    end
                end
                default:
                begin
                    phase_next = csep_pkg::PH_CMD;
                end
            endcase

            // end of track from a command, or from stream end with no other result
            if (eot1 || (stream_end && !emit1))
            begin
                res1.kind        = csep_pkg::KIND_EOT;
                res1.status      = csep_pkg::ST_META;
                res1.data_first  = csep_pkg::META_EOT;
                res1.data_second = 8'd0;
                res1.error       = err1;
                emit1            = 1'b1;
            end

            if (eot1 || stream_end)
            begin
                ended_next = 1'b1;
                phase_next = csep_pkg::PH_CMD;
            end

            res1.delta_ticks     = acc_mid;
            acc_next             = emit1 ? '0 : acc_mid;
            push                 = emit1;
            push_data.first      = res1;
            push_data.second_eot = stream_end && !eot1 && (res1.kind != csep_pkg::KIND_EOT);
        end
    end

endmodule

// ----- rtl/core/csep_queue.sv -----
// short request queue between the front end and the back end
// depends on csep_pkg

module csep_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csep_pkg::request_t  push_data,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output csep_pkg::request_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csep_pkg::request_t  mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/csep_back.sv -----
// back end: drains queued requests into the registered result channel
// depends on csep_pkg

module csep_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  csep_pkg::request_t  q_head,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output csep_pkg::result_t   out_res,
    output logic                out_last
);

    logic               valid_reg, valid_next;
    logic               pending_reg, pending_next;
    csep_pkg::result_t  res_reg, res_next;
    logic               last_reg, last_next;
    logic               load;

    assign load      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        res_next     = res_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        if (load)
        begin
            if (pending_reg)
            begin
                valid_next           = 1'b1;
                pending_next         = 1'b0;
                res_next             = '0;
                res_next.kind        = csep_pkg::KIND_EOT;
                res_next.status      = csep_pkg::ST_META;
                res_next.data_first  = csep_pkg::META_EOT;
                last_next            = 1'b1;
            end
            else if (!q_empty)
            begin
                pop          = 1'b1;
                valid_next   = 1'b1;
                pending_next = q_head.second_eot;
                res_next     = q_head.first;
                last_next    = !q_head.second_eot;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

endmodule

// ----- rtl/core/compact_song_event_parser.sv -----
// top level of the compact song event parser
// depends on csep_pkg, csep_front, csep_queue, csep_back
//
// Accepts one stream byte per clock while the queue is not full; the front end
// updates parse state and the saturating delay accumulator in the accept cycle
// and queues any results (QUEUE_DEPTH requests deep), and a registered output
// stage drains them one result per cycle while out_stall is low; each result
// passes the queue, then the output register. A byte that causes two results
// (an event completed by the stream_end byte) gives the event, then an end of
// track; in_stall rises only when the queue is full. After end of track all
// bytes are taken and dropped until reset. note_off_velocity is written through
// the cfg channel, which is always ready, and should change only while idle.

module compact_song_event_parser
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [6:0]                  note_off_velocity,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  in_byte,
    input  logic                        stream_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  kind,
    output logic [7:0]                  status,
    output logic [7:0]                  data_first,
    output logic [7:0]                  data_second,
    output logic [csep_pkg::ACC_W-1:0]  delta_ticks,
    output logic                        error,
    output logic                        last
);

    logic                q_full;
    logic                q_empty;
    logic                push;
    logic                pop;
    csep_pkg::request_t  push_data;
    csep_pkg::request_t  q_head;
    csep_pkg::result_t   res;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    csep_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_valid && !in_stall),
        .in_byte    (in_byte),
        .stream_end (stream_end),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (note_off_velocity),
        .push       (push),
        .push_data  (push_data)
    );

    csep_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    csep_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (res),
        .out_last  (last)
    );

    assign kind        = res.kind;
    assign status      = res.status;
    assign data_first  = res.data_first;
    assign data_second = res.data_second;
    assign delta_ticks = res.delta_ticks;
    assign error       = res.error;

endmodule

// ----- rtl/core/csep_checker.sv -----
// port-level checks for the compact song event parser, bound to the top level
// depends on csep_pkg and compact_song_event_parser

module csep_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  status,
    input  logic [7:0]  data_first,
    input  logic [7:0]  data_second,
    input  logic        error,
    input  logic        last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // end of track carries the meta marker and is the final result of its byte
    a_eot_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == csep_pkg::KIND_EOT |->
        status == csep_pkg::ST_META && data_first == csep_pkg::META_EOT && last)
        else $error("malformed end of track");

    // nothing follows a delivered end of track
    a_eot_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == csep_pkg::KIND_EOT |=> !out_valid)
        else $error("result after end of track");

    // sysex bytes carry the sysex status and no second byte
    a_sysex_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == csep_pkg::KIND_SYSEX |->
        status == csep_pkg::ST_SYSEX_START && data_second == 8'd0 && !error)
        else $error("malformed sysex result");

    // error only on end of track
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> kind == csep_pkg::KIND_EOT)
        else $error("error flag on a non end of track result");

endmodule

bind compact_song_event_parser csep_checker u_csep_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .status      (status),
    .data_first  (data_first),
    .data_second (data_second),
    .error       (error),
    .last        (last)
);
